/* hdl/cbr_pkg.sv */
// shared types and constants for the cartridge bus rom responder
// depends on nothing; used by every module of the block by scoped names

package cbr_pkg;

    // field widths
    localparam int WORD_W = 16;
    localparam int IMG_W  = 22;
    localparam int LIDX_W = 20;
    localparam int OFS_W  = 9;
    localparam int ADR_W  = 32;

    // default store depth in halfwords
    localparam int ROM_HALFWORDS_DEF = 1048576;

    // bus address windows
    localparam logic [ADR_W-1:0] ROM_BASE = 32'h1000_0000;
    localparam logic [ADR_W-1:0] DOM2A_LO = 32'h0500_0000;
    localparam logic [ADR_W-1:0] DOM2A_HI = 32'h05FF_FFFF;
    localparam logic [ADR_W-1:0] DOM1A_LO = 32'h0600_0000;
    localparam logic [ADR_W-1:0] DOM1A_HI = 32'h07FF_FFFF;
    localparam logic [ADR_W-1:0] DOM2B_LO = 32'h0800_0000;
    localparam logic [ADR_W-1:0] DOM2B_HI = 32'h0FFF_FFFF;

    // configuration register index
    localparam logic REG_IMAGE_BYTES = 1'b0;

    // input beat action codes
    typedef enum logic [1:0] {
        ACT_ADDR      = 2'd0,
        ACT_READ      = 2'd1,
        ACT_BUS_RESET = 2'd2,
        ACT_LOAD      = 2'd3
    } action_t;

    // registered address decode
    typedef struct packed {
        logic             hit;
        logic [IMG_W-1:0] rel;
    } decode_t;

endpackage

/* hdl/cbr_rom_mem.sv */
// single-port synchronous halfword store holding the rom image
// depends on cbr_pkg for the data width

module cbr_rom_mem #(
    parameter int DEPTH  = cbr_pkg::ROM_HALFWORDS_DEF,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  logic                       clk,
    input  logic                       en,
    input  logic                       we,
    input  logic [ADDR_W-1:0]          addr,
    input  logic [cbr_pkg::WORD_W-1:0] wdata,
    output logic [cbr_pkg::WORD_W-1:0] rdata
);

    logic [cbr_pkg::WORD_W-1:0] mem [DEPTH];

    // write or registered read, one access per cycle
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            if (we)
            begin
                mem[addr] <= wdata;
            end
            else
            begin
                rdata <= mem[addr];
            end
        end
    end

endmodule

/* hdl/cbr_addr_decode.sv */
// registered window decode of the latched bus address
// depends on cbr_pkg for windows, widths and the decode struct

module cbr_addr_decode (
    input  logic                       clk,
    input  logic [cbr_pkg::ADR_W-1:0]  addr,
    input  logic [cbr_pkg::IMG_W-1:0]  image_bytes,
    output cbr_pkg::decode_t           dec_reg
);

    logic [cbr_pkg::ADR_W:0] rom_top;
    logic                    rom_hit;
    logic                    dom_hit;
    logic                    short_hit;
    cbr_pkg::decode_t        dec_next;

    // window compares; relative address is the low bits in both hit cases
    always_comb
    begin
        rom_top   = {1'b0, cbr_pkg::ROM_BASE}
                  + {{(cbr_pkg::ADR_W + 1 - cbr_pkg::IMG_W){1'b0}}, image_bytes};
        rom_hit   = (addr >= cbr_pkg::ROM_BASE) && ({1'b0, addr} <= rom_top);
        dom_hit   = ((addr >= cbr_pkg::DOM2A_LO) && (addr <= cbr_pkg::DOM2A_HI))
                 || ((addr >= cbr_pkg::DOM1A_LO) && (addr <= cbr_pkg::DOM1A_HI))
                 || ((addr >= cbr_pkg::DOM2B_LO) && (addr <= cbr_pkg::DOM2B_HI));
        short_hit = addr <= {{(cbr_pkg::ADR_W - cbr_pkg::IMG_W){1'b0}}, image_bytes};
        dec_next.hit = rom_hit || (!dom_hit && short_hit);
        dec_next.rel = addr[cbr_pkg::IMG_W-1:0];
    end

    // decode follows the address every cycle
    always_ff @(posedge clk)
    begin
        dec_reg <= dec_next;
    end

endmodule

/* hdl/cbr_seq.sv */
// bus state, read sequencer and output register of the rom responder
// depends on cbr_pkg; drives the store port and takes the registered decode

module cbr_seq #(
    parameter int ROM_HALFWORDS = cbr_pkg::ROM_HALFWORDS_DEF,
    parameter int ADDR_W        = $clog2(ROM_HALFWORDS)
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  cbr_pkg::action_t            action,
    input  logic [cbr_pkg::WORD_W-1:0]  bus_word,
    input  logic [cbr_pkg::LIDX_W-1:0]  load_index,
    input  logic                        reset_released,
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic [cbr_pkg::WORD_W-1:0]  read_data,
    output logic                        release_bus,
    output logic [cbr_pkg::ADR_W-1:0]   latched_addr,
    input  cbr_pkg::decode_t            dec,
    output logic                        mem_en,
    output logic                        mem_we,
    output logic [ADDR_W-1:0]           mem_addr,
    output logic [cbr_pkg::WORD_W-1:0]  mem_wdata,
    input  logic [cbr_pkg::WORD_W-1:0]  mem_rdata
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_RD,
        S_CAP
    } state_t;

    localparam int SUM_W = cbr_pkg::IMG_W + 1;
    localparam int IDX_W = SUM_W - 1;

    state_t                      state_reg, state_next;
    logic [cbr_pkg::ADR_W-1:0]   latched_addr_reg, latched_addr_next;
    logic [cbr_pkg::WORD_W-1:0]  high_half_reg, high_half_next;
    logic                        toggle_reg, toggle_next;
    logic [cbr_pkg::OFS_W-1:0]   offset_reg, offset_next;
    logic                        run_reg, run_next;
    logic                        rd_zero_reg, rd_zero_next;
    logic                        rd_release_reg, rd_release_next;
    logic                        out_valid_reg, out_valid_next;
    logic [cbr_pkg::WORD_W-1:0]  out_data_reg, out_data_next;
    logic                        out_release_reg, out_release_next;

    logic                        cap_go;
    logic                        accept;
    logic                        ld_in_range;
    logic [SUM_W-1:0]            byte_sum;
    logic [IDX_W-1:0]            rd_idx;
    logic                        rd_in_range;

    // output slot is free or leaves this cycle
    assign cap_go   = !out_valid_reg || out_ready;
    assign in_ready = (state_reg == S_IDLE) || ((state_reg == S_CAP) && cap_go);
    assign accept   = in_valid && in_ready;

    // store index of the read beat and range checks
    assign byte_sum    = {1'b0, dec.rel}
                       + {{(SUM_W - cbr_pkg::OFS_W){1'b0}}, offset_reg};
    assign rd_idx      = byte_sum[SUM_W-1:1];
    assign rd_in_range = 32'(rd_idx) < 32'(ROM_HALFWORDS);
    assign ld_in_range = 32'(load_index) < 32'(ROM_HALFWORDS);

    // store port: loads at accept, reads in the read cycle
    always_comb
    begin
        mem_we    = accept && (action == cbr_pkg::ACT_LOAD) && ld_in_range;
        mem_en    = mem_we || (state_reg == S_RD);
        mem_addr  = (state_reg == S_RD) ? ADDR_W'(rd_idx) : ADDR_W'(load_index);
        mem_wdata = bus_word;
    end

    // next-state logic
    always_comb
    begin
        state_next        = state_reg;
        latched_addr_next = latched_addr_reg;
        high_half_next    = high_half_reg;
        toggle_next       = toggle_reg;
        offset_next       = offset_reg;
        run_next          = run_reg;
        rd_zero_next      = rd_zero_reg;
        rd_release_next   = rd_release_reg;
        out_valid_next    = out_valid_reg && !out_ready;
        out_data_next     = out_data_reg;
        out_release_next  = out_release_reg;

        // read cycle: store access issued, offset steps
        if (state_reg == S_RD)
        begin
            rd_zero_next    = !dec.hit || !rd_in_range;
            rd_release_next = offset_reg[1];
            offset_next     = offset_reg + cbr_pkg::OFS_W'(2);
            state_next      = S_CAP;
        end

        // capture store data into the output register
        if ((state_reg == S_CAP) && cap_go)
        begin
            out_valid_next   = 1'b1;
            out_data_next    = rd_zero_reg ? '0 : mem_rdata;
            out_release_next = rd_release_reg;
            state_next       = S_IDLE;
        end

        // accepted input beat
        if (accept)
        begin
            case (action)
                cbr_pkg::ACT_ADDR:
                begin
                    if (!toggle_reg)
                    begin
                        high_half_next = bus_word;
                        toggle_next    = 1'b1;
                    end
                    else
                    begin
                        latched_addr_next = {high_half_reg, bus_word};
                        offset_next       = '0;
                        toggle_next       = 1'b0;
                    end
                end
                cbr_pkg::ACT_READ:
                begin
                    if (run_reg)
                    begin
                        state_next = S_RD;
                    end
                end
                cbr_pkg::ACT_BUS_RESET:
                begin
                    if (reset_released)
                    begin
                        run_next = 1'b1;
                    end
                    else
                    begin
                        latched_addr_next = '0;
                        high_half_next    = '0;
                        toggle_next       = 1'b0;
                        offset_next       = '0;
                        run_next          = 1'b0;
                    end
                end
                default:
                begin
                    // rom load goes straight to the store port
                end
            endcase
        end
    end

    // state and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            latched_addr_reg <= '0;
            high_half_reg    <= '0;
            toggle_reg       <= 1'b0;
            offset_reg       <= '0;
            run_reg          <= 1'b0;
            rd_zero_reg      <= 1'b0;
            rd_release_reg   <= 1'b0;
            out_valid_reg    <= 1'b0;
            out_data_reg     <= '0;
            out_release_reg  <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            latched_addr_reg <= latched_addr_next;
            high_half_reg    <= high_half_next;
            toggle_reg       <= toggle_next;
            offset_reg       <= offset_next;
            run_reg          <= run_next;
            rd_zero_reg      <= rd_zero_next;
            rd_release_reg   <= rd_release_next;
            out_valid_reg    <= out_valid_next;
            out_data_reg     <= out_data_next;
            out_release_reg  <= out_release_next;
        end
    end

    assign out_valid    = out_valid_reg;
    assign read_data    = out_data_reg;
    assign release_bus  = out_release_reg;
    assign latched_addr = latched_addr_reg;

    // read cycle always leads to capture
    a_rd_to_cap: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_RD) |=> (state_reg == S_CAP))
        else $error("read cycle not followed by capture");

    // store is read, never written, in the read cycle
    a_rd_port: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_RD) |-> (mem_en && !mem_we))
        else $error("store port conflict in read cycle");

    // capture waits while the output is stalled
    a_cap_hold: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == S_CAP) && out_valid_reg && !out_ready) |=> (state_reg == S_CAP))
        else $error("capture over a pending result");

    // a read while stopped leaves the offset alone
    a_stopped_read: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && (action == cbr_pkg::ACT_READ) && !run_reg)
        |=> ($stable(offset_reg) && (state_reg != S_RD)))
        else $error("read taken while stopped");

endmodule

/* hdl/cartridge_bus_rom_responder_core.sv */
// top level of the cartridge bus rom responder: config port and submodules
// depends on cbr_pkg, cbr_rom_mem, cbr_addr_decode and cbr_seq

// Target side of a multiplexed 16-bit cartridge bus serving a rom image from a
// single-port synchronous store of ROM_HALFWORDS halfwords. Address halves,
// bus reset changes and rom loads are each done in their accept cycle. A read
// strobe while running moves through the read state, where the store is read,
// and the capture state, where the store data lands in the output register and
// the next beat may already be accepted, so a new beat may be taken before a
// read is through. A result waiting at the output does not block address,
// reset or load beats; a following read waits in its capture cycle for the
// output slot, and no beat is taken while it waits. image_bytes sits at byte
// address 0.

module cartridge_bus_rom_responder_core #(
    parameter int ROM_HALFWORDS = cbr_pkg::ROM_HALFWORDS_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [2:0]                  paddr,
    input  logic [31:0]                 pwdata,
    output logic [31:0]                 prdata,
    output logic                        pready,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  logic [1:0]                  action,
    input  logic [cbr_pkg::WORD_W-1:0]  bus_word,
    input  logic [cbr_pkg::LIDX_W-1:0]  load_index,
    input  logic                        reset_released,
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic [cbr_pkg::WORD_W-1:0]  read_data,
    output logic                        release_bus
);

    localparam int ADDR_W = $clog2(ROM_HALFWORDS);

    logic [cbr_pkg::IMG_W-1:0]   image_bytes_reg;
    logic [cbr_pkg::ADR_W-1:0]   latched_addr;
    cbr_pkg::decode_t            dec;
    logic                        mem_en;
    logic                        mem_we;
    logic [ADDR_W-1:0]           mem_addr;
    logic [cbr_pkg::WORD_W-1:0]  mem_wdata;
    logic [cbr_pkg::WORD_W-1:0]  mem_rdata;
    logic                        reg_sel;

    // config register, word index taken from paddr bit 2
    assign pready  = 1'b1;
    assign reg_sel = paddr[2] == cbr_pkg::REG_IMAGE_BYTES;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            image_bytes_reg <= '0;
        end
        else if (psel && penable && pwrite && pready && reg_sel)
        begin
            image_bytes_reg <= pwdata[cbr_pkg::IMG_W-1:0];
        end
    end

    assign prdata = reg_sel ? {{(32 - cbr_pkg::IMG_W){1'b0}}, image_bytes_reg} : '0;

    // address window decode
    cbr_addr_decode u_decode (
        .clk         (clk),
        .addr        (latched_addr),
        .image_bytes (image_bytes_reg),
        .dec_reg     (dec)
    );

    // bus state and read sequencer
    cbr_seq #(
        .ROM_HALFWORDS (ROM_HALFWORDS),
        .ADDR_W        (ADDR_W)
    ) u_seq (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .action         (cbr_pkg::action_t'(action)),
        .bus_word       (bus_word),
        .load_index     (load_index),
        .reset_released (reset_released),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .read_data      (read_data),
        .release_bus    (release_bus),
        .latched_addr   (latched_addr),
        .dec            (dec),
        .mem_en         (mem_en),
        .mem_we         (mem_we),
        .mem_addr       (mem_addr),
        .mem_wdata      (mem_wdata),
        .mem_rdata      (mem_rdata)
    );

    // rom image store
    cbr_rom_mem #(
        .DEPTH  (ROM_HALFWORDS),
        .ADDR_W (ADDR_W)
    ) u_mem (
        .clk   (clk),
        .en    (mem_en),
        .we    (mem_we),
        .addr  (mem_addr),
        .wdata (mem_wdata),
        .rdata (mem_rdata)
    );

endmodule
